// File: sv/psq_pkg.sv
// ----------------------------------------------------------------------------
// psq_pkg
// Shared sizes, codes and types of the priority select queue.
// ----------------------------------------------------------------------------
package psq_pkg;

    localparam int DEPTH       = 16;
    localparam int PRIO_LEVELS = 128;
    localparam int HANDLE_BITS = 16;

    // Fixed field widths of the stream words.
    localparam int HANDLE_FIELD_W = 16;
    localparam int PRIO_FIELD_W   = 7;
    localparam int OCC_FIELD_W    = 5;

    // Stored widths follow from the parameters above.
    localparam int HANDLE_W = (HANDLE_BITS < HANDLE_FIELD_W) ? HANDLE_BITS : HANDLE_FIELD_W;
    localparam int PRIO_W   = PRIO_FIELD_W;
    localparam int PRIO_MAX = ((PRIO_LEVELS - 1) > ((1 << PRIO_FIELD_W) - 1)) ?
                              ((1 << PRIO_FIELD_W) - 1) : (PRIO_LEVELS - 1);
    localparam int WORD_W   = PRIO_W + HANDLE_W;
    localparam int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W    = $clog2(DEPTH + 1);

    // Operation codes carried in s_tuser.
    localparam logic KIND_ENQ = 1'b0;
    localparam logic KIND_DEQ = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SHIFT,
        ST_DONE
    } state_t;

endpackage

// File: sv/psq_ram.sv
// ----------------------------------------------------------------------------
// psq_ram
// Generic single write port, single read port RAM with a registered read.
// ----------------------------------------------------------------------------
module psq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   aclk,
    input  logic                                   wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic                                   rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: sv/priority_select_queue_unit.sv
// ----------------------------------------------------------------------------
// priority_select_queue_unit
// Bounded queue of process handles with priorities, dequeued in FIFO or
// smallest-priority-first order, with its entries held in a RAM.
// ----------------------------------------------------------------------------
//
// Channel   Dir  Handshake            Word contents
// s_        in   s_tvalid/s_tready    tuser: kind; tdata: handle, prio
// m_        out  m_tvalid/m_tready    tuser: out_valid, rejected;
//                                     tdata: out_handle, out_prio, occupancy
// cfg_      in   cfg_valid/cfg_ready  cfg_data: priority_mode
//
// An enqueue, and any rejected word, passes from acceptance through ST_DONE to
// the result register. A dequeue searches in ST_SCAN, reading every stored
// entry in priority mode (one RAM read per entry during the minimum search)
// and only the head in FIFO mode; the shift-up in ST_SHIFT then moves one
// entry per cycle through the single RAM read and write port.
// One word is in flight at a time; the next is accepted once the result has
// been placed in the output register, which may still wait for m_tready.
// Reset (aresetn low, synchronous) empties the queue and selects priority
// mode; the RAM is not cleared because only entries below the count are read.
// ----------------------------------------------------------------------------
module priority_select_queue_unit
    import psq_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic        s_tuser,   // [0] kind
    input  logic [23:0] s_tdata,   // [15:0] handle, [22:16] prio, [23] zero

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [1:0]  m_tuser,   // [0] out_valid, [1] rejected
    output logic [31:0] m_tdata,   // [15:0] out_handle, [22:16] out_prio,
                                   // [27:23] occupancy, [31:28] zero

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data   // [0] priority_mode
);

    state_t               state_reg, state_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic                 prio_mode_reg, prio_mode_next;

    // Search and shift bookkeeping.
    logic [CNT_W-1:0]     scan_idx_reg, scan_idx_next;   // next address to read
    logic [CNT_W-1:0]     data_idx_reg, data_idx_next;   // index of rd_data
    logic [CNT_W-1:0]     best_idx_reg, best_idx_next;
    logic [PRIO_W-1:0]    best_prio_reg, best_prio_next;
    logic [HANDLE_W-1:0]  best_handle_reg, best_handle_next;
    logic [CNT_W-1:0]     sh_idx_reg, sh_idx_next;       // entry being rewritten

    // Pending result of the word in flight.
    logic                 res_valid_reg, res_valid_next;
    logic                 res_rej_reg, res_rej_next;
    logic [HANDLE_W-1:0]  res_handle_reg, res_handle_next;
    logic [PRIO_W-1:0]    res_prio_reg, res_prio_next;

    // Output register.
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [1:0]           m_tuser_reg, m_tuser_next;
    logic [31:0]          m_tdata_reg, m_tdata_next;

    // RAM port signals.
    logic                 wr_en;
    logic [ADDR_W-1:0]    wr_addr;
    logic [WORD_W-1:0]    wr_data;
    logic                 rd_en;
    logic [ADDR_W-1:0]    rd_addr;
    logic [WORD_W-1:0]    rd_data;

    logic [HANDLE_W-1:0]  in_handle;
    logic [PRIO_W-1:0]    in_prio;
    logic [PRIO_W-1:0]    in_prio_sat;
    logic [PRIO_W-1:0]    cand_prio;
    logic [HANDLE_W-1:0]  cand_handle;
    logic                 cand_take;
    logic [CNT_W-1:0]     pick_idx;
    logic [CNT_W:0]       pick_next;
    logic [CNT_W:0]       sh_ahead;

    psq_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tuser   = m_tuser_reg;
    assign m_tdata   = m_tdata_reg;

    assign in_handle   = s_tdata[HANDLE_W-1:0];
    assign in_prio     = s_tdata[HANDLE_FIELD_W +: PRIO_FIELD_W];
    // Priorities above the top level are stored as the top level.
    assign in_prio_sat = (in_prio > PRIO_W'(PRIO_MAX)) ? PRIO_W'(PRIO_MAX) : in_prio;

    // The RAM word holds the priority above the handle.
    assign cand_prio   = rd_data[WORD_W-1:HANDLE_W];
    assign cand_handle = rd_data[HANDLE_W-1:0];
    // Strict less-than keeps the earliest entry on equal priorities.
    assign cand_take   = (data_idx_reg == '0) || (cand_prio < best_prio_reg);
    assign pick_idx    = cand_take ? data_idx_reg : best_idx_reg;
    assign pick_next   = {1'b0, pick_idx} + (CNT_W+1)'(1);
    assign sh_ahead    = {1'b0, sh_idx_reg} + (CNT_W+1)'(2);

    always_comb begin
        state_next       = state_reg;
        count_next       = count_reg;
        prio_mode_next   = prio_mode_reg;
        scan_idx_next    = scan_idx_reg;
        data_idx_next    = data_idx_reg;
        best_idx_next    = best_idx_reg;
        best_prio_next   = best_prio_reg;
        best_handle_next = best_handle_reg;
        sh_idx_next      = sh_idx_reg;
        res_valid_next   = res_valid_reg;
        res_rej_next     = res_rej_reg;
        res_handle_next  = res_handle_reg;
        res_prio_next    = res_prio_reg;
        m_tvalid_next    = m_tvalid_reg;
        m_tuser_next     = m_tuser_reg;
        m_tdata_next     = m_tdata_reg;
        wr_en            = 1'b0;
        wr_addr          = count_reg[ADDR_W-1:0];
        wr_data          = {in_prio_sat, in_handle};
        rd_en            = 1'b0;
        rd_addr          = '0;

        if (cfg_valid && cfg_ready) begin
            prio_mode_next = cfg_data;
        end

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    res_valid_next  = 1'b0;
                    res_rej_next    = 1'b0;
                    res_handle_next = '0;
                    res_prio_next   = '0;
                    if (s_tuser == KIND_ENQ) begin
                        // Append at the tail unless the queue is full.
                        if (count_reg >= CNT_W'(DEPTH)) begin
                            res_rej_next = 1'b1;
                        end else begin
                            wr_en      = 1'b1;
                            count_next = count_reg + CNT_W'(1);
                        end
                        state_next = ST_DONE;
                    end else if (count_reg == '0) begin
                        res_rej_next = 1'b1;
                        state_next   = ST_DONE;
                    end else begin
                        // Start the search with the head entry.
                        rd_en         = 1'b1;
                        rd_addr       = '0;
                        scan_idx_next = CNT_W'(1);
                        data_idx_next = '0;
                        state_next    = ST_SCAN;
                    end
                end
            end

            ST_SCAN: begin
                if (cand_take) begin
                    best_idx_next    = data_idx_reg;
                    best_prio_next   = cand_prio;
                    best_handle_next = cand_handle;
                end
                if (prio_mode_reg && (scan_idx_reg < count_reg)) begin
                    rd_en         = 1'b1;
                    rd_addr       = scan_idx_reg[ADDR_W-1:0];
                    data_idx_next = scan_idx_reg;
                    scan_idx_next = scan_idx_reg + CNT_W'(1);
                end else begin
                    res_valid_next  = 1'b1;
                    res_handle_next = cand_take ? cand_handle : best_handle_reg;
                    res_prio_next   = cand_take ? cand_prio : best_prio_reg;
                    if (pick_next < {1'b0, count_reg}) begin
                        // Later entries move up one place, one per cycle.
                        rd_en       = 1'b1;
                        rd_addr     = pick_next[ADDR_W-1:0];
                        sh_idx_next = pick_idx;
                        state_next  = ST_SHIFT;
                    end else begin
                        count_next = count_reg - CNT_W'(1);
                        state_next = ST_DONE;
                    end
                end
            end

            ST_SHIFT: begin
                wr_en   = 1'b1;
                wr_addr = sh_idx_reg[ADDR_W-1:0];
                wr_data = rd_data;
                if (sh_ahead < {1'b0, count_reg}) begin
                    rd_en       = 1'b1;
                    rd_addr     = sh_ahead[ADDR_W-1:0];
                    sh_idx_next = sh_idx_reg + CNT_W'(1);
                end else begin
                    count_next = count_reg - CNT_W'(1);
                    state_next = ST_DONE;
                end
            end

            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = {res_rej_reg, res_valid_reg};
                    m_tdata_next  = {4'b0000, OCC_FIELD_W'(count_reg), res_prio_reg,
                                     HANDLE_FIELD_W'(res_handle_reg)};
                    state_next    = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            prio_mode_reg <= 1'b1;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            prio_mode_reg <= prio_mode_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
        scan_idx_reg    <= scan_idx_next;
        data_idx_reg    <= data_idx_next;
        best_idx_reg    <= best_idx_next;
        best_prio_reg   <= best_prio_next;
        best_handle_reg <= best_handle_next;
        sh_idx_reg      <= sh_idx_next;
        res_valid_reg   <= res_valid_next;
        res_rej_reg     <= res_rej_next;
        res_handle_reg  <= res_handle_next;
        res_prio_reg    <= res_prio_next;
        m_tuser_reg     <= m_tuser_next;
        m_tdata_reg     <= m_tdata_next;
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count exceeds depth");

    a_valid_not_rejected: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
        else $error("result both valid and rejected");

    a_shift_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        (wr_en && rd_en) |-> (wr_addr != rd_addr))
        else $error("RAM read and write hit the same entry");

    a_dequeue_drops_one: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SHIFT && state_next == ST_DONE)
        |=> (count_reg == $past(count_reg) - CNT_W'(1)))
        else $error("dequeue did not remove exactly one entry");

    a_accept_idle_only: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg != ST_IDLE))
        else $error("accepted word did not start processing");
`endif

endmodule
